@@ hdl/bmsd_pkg.sv @@
// shared constants, types and helpers of the block mean symbol decoder
package bmsd_pkg;

  localparam int unsigned MaxBlocksAcross = 512;
  localparam int unsigned MaxBlockEdge    = 32;
  localparam int unsigned ColW   = $clog2(MaxBlocksAcross);
  localparam int unsigned SumW   = 18;
  localparam int unsigned AddrW  = 5;

  // register indexes
  localparam logic [2:0] RegLineWidth     = 3'd0;
  localparam logic [2:0] RegLineCount     = 3'd1;
  localparam logic [2:0] RegBlockEdge     = 3'd2;
  localparam logic [2:0] RegBlocksAcross  = 3'd3;
  localparam logic [2:0] RegDataBlockRows = 3'd4;
  localparam logic [2:0] RegSyncBlockRows = 3'd5;
  localparam logic [2:0] RegBitsPerBlock  = 3'd6;
  localparam logic [2:0] RegEdgeMargin    = 3'd7;

  typedef struct packed {
    logic [7:0]  pixel;
    logic        last_of_stream;
  } pix_t;

  typedef struct packed {
    logic [2:0]  symbol;
    logic [7:0]  block_mean;
    logic [8:0]  block_column;
    logic [11:0] data_row;
    logic        last_of_frame;
  } sym_t;

  // quantize a mean into 2, 4 or 8 levels
  function automatic logic [2:0] level_of(input logic [7:0] mean, input logic [1:0] mode);
    logic [2:0] lv;
    lv = 3'd0;
    if (mode == 2'd1) begin
      lv = (mean >= 8'd128) ? 3'd1 : 3'd0;
    end else if (mode == 2'd2) begin
      if (mean < 8'd43) lv = 3'd0;
      else if (mean < 8'd128) lv = 3'd1;
      else if (mean < 8'd213) lv = 3'd2;
      else lv = 3'd3;
    end else begin
      if (mean < 8'd18) lv = 3'd0;
      else if (mean < 8'd55) lv = 3'd1;
      else if (mean < 8'd91) lv = 3'd2;
      else if (mean < 8'd128) lv = 3'd3;
      else if (mean < 8'd164) lv = 3'd4;
      else if (mean < 8'd200) lv = 3'd5;
      else if (mean < 8'd237) lv = 3'd6;
      else lv = 3'd7;
    end
    return lv;
  endfunction

endpackage

@@ hdl/bmsd_if.sv @@
// valid/ready stream interfaces for pixels and symbols
interface bmsd_pix_if;
  import bmsd_pkg::*;
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bmsd_sym_if;
  import bmsd_pkg::*;
  logic valid;
  logic ready;
  sym_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/bmsd_div.sv @@
// iterative restoring divider: floor(sum / divisor), clipped to 255
module bmsd_div
  import bmsd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SumW-1:0] sum_i,
  input  logic [10:0]     div_i,
  output logic            done_o,
  output logic [7:0]      quot_o
);
  localparam int unsigned CntW = $clog2(SumW + 1);

  logic [SumW-1:0] quot_q, quot_d;
  logic [SumW:0]   rem_q, rem_d;
  logic [10:0]     dv_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [SumW:0]   trial;

  // one quotient bit per cycle
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[SumW-1:0], quot_q[SumW-1]};
    if (start_i) begin
      quot_d = sum_i;
      rem_d  = '0;
      cnt_d  = CntW'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {{(SumW-10){1'b0}}, dv_q}) begin
        rem_d  = trial - {{(SumW-10){1'b0}}, dv_q};
        quot_d = {quot_q[SumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) dv_q <= div_i;
  end

  assign done_o = done_q;
  assign quot_o = (quot_q > SumW'(255)) ? 8'd255 : quot_q[7:0];
endmodule

@@ hdl/block_mean_symbol_decoder.sv @@
// top level: position tracking, column sum memory, divider and output register
// A pixel is taken in one cycle and its column sum is read, updated and written
// back in the next; the next pixel may enter in that cycle, with the just
// written sum forwarded when it hits the same column. So pixels flow at one per
// cycle except at a block's last inner pixel: that one enters the 18-step
// restoring divider and input is held until the symbol lands in the output
// register. A block without inner pixels is emitted without the divider. Input
// also stalls while a finished symbol waits to be taken.
module block_mean_symbol_decoder
  import bmsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bmsd_pix_if.sink    pix_in,
  bmsd_sym_if.source  sym_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // configuration registers
  logic [12:0] line_width_q, line_count_q, data_rows_q, sync_rows_q;
  logic [5:0]  edge_q;
  logic [9:0]  across_q;
  logic [1:0]  bpb_q;
  logic [3:0]  margin_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= 13'd1920;
      line_count_q <= 13'd1080;
      edge_q       <= 6'd4;
      across_q     <= 10'd480;
      data_rows_q  <= 13'd268;
      sync_rows_q  <= 13'd2;
      bpb_q        <= 2'd2;
      margin_q     <= 4'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegLineWidth:     line_width_q <= pwdata[12:0];
        RegLineCount:     line_count_q <= pwdata[12:0];
        RegBlockEdge:     edge_q       <= pwdata[5:0];
        RegBlocksAcross:  across_q     <= pwdata[9:0];
        RegDataBlockRows: data_rows_q  <= pwdata[12:0];
        RegSyncBlockRows: sync_rows_q  <= pwdata[12:0];
        RegBitsPerBlock:  bpb_q        <= pwdata[1:0];
        RegEdgeMargin:    margin_q     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      RegLineWidth:     prdata = {19'd0, line_width_q};
      RegLineCount:     prdata = {19'd0, line_count_q};
      RegBlockEdge:     prdata = {26'd0, edge_q};
      RegBlocksAcross:  prdata = {22'd0, across_q};
      RegDataBlockRows: prdata = {19'd0, data_rows_q};
      RegSyncBlockRows: prdata = {19'd0, sync_rows_q};
      RegBitsPerBlock:  prdata = {30'd0, bpb_q};
      RegEdgeMargin:    prdata = {28'd0, margin_q};
      default:          prdata = '0;
    endcase
  end

  // clamped limits
  logic [12:0] lw, lc;
  logic [5:0]  e;
  logic [9:0]  ba;
  logic [5:0]  inner;
  logic [5:0]  hi;
  logic [14:0] cols_limit;
  logic [13:0] rows_end;

  always_comb begin
    lw = (line_width_q == 13'd0) ? 13'd1 : (line_width_q > 13'd4096 ? 13'd4096 : line_width_q);
    lc = (line_count_q == 13'd0) ? 13'd1 : (line_count_q > 13'd4096 ? 13'd4096 : line_count_q);
    e  = (edge_q == 6'd0) ? 6'd1 : (edge_q > 6'd32 ? 6'd32 : edge_q);
    ba = (across_q == 10'd0) ? 10'd1 : (across_q > 10'd512 ? 10'd512 : across_q);
    inner = ({1'b0, margin_q, 1'b0} < e) ? e - {1'b0, margin_q, 1'b0} : 6'd0;
    hi = {2'b0, margin_q} + inner;
    cols_limit = 15'(ba) * 15'(e);
    rows_end = 14'(sync_rows_q) + 14'(data_rows_q);
  end

  // position counters
  logic [11:0] pcol_q, prow_q, brow_q;
  logic [4:0]  cib_q, rib_q;
  logic [8:0]  bcol_q;
  logic        in_cols, in_rows, inner_hit, first_hit, last_hit, empty_emit;
  logic        busy_q, obuf_full_q;
  logic        accept;

  always_comb begin
    in_cols = {3'b0, pcol_q} < cols_limit;
    in_rows = ({2'b0, brow_q} >= {1'b0, sync_rows_q}) && ({2'b0, brow_q} < rows_end);
    inner_hit = in_cols && in_rows && (inner != 6'd0) &&
                ({1'b0, cib_q} >= {2'b0, margin_q}) && ({1'b0, cib_q} < hi) &&
                ({1'b0, rib_q} >= {2'b0, margin_q}) && ({1'b0, rib_q} < hi);
    first_hit = ({1'b0, cib_q} == {2'b0, margin_q}) && ({1'b0, rib_q} == {2'b0, margin_q});
    last_hit  = ({1'b0, cib_q} == hi - 6'd1) && ({1'b0, rib_q} == hi - 6'd1);
    empty_emit = in_cols && in_rows && (inner == 6'd0) &&
                 ({1'b0, cib_q} == e - 6'd1) && ({1'b0, rib_q} == e - 6'd1);
  end

  assign pix_in.ready = !busy_q && !obuf_full_q;
  assign accept = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcol_q <= '0; prow_q <= '0; cib_q <= '0; rib_q <= '0; bcol_q <= '0; brow_q <= '0;
    end else if (accept) begin
      if (pix_in.data.last_of_stream) begin
        pcol_q <= '0; prow_q <= '0; cib_q <= '0; rib_q <= '0; bcol_q <= '0; brow_q <= '0;
      end else if (13'(pcol_q) + 13'd1 >= lw) begin
        pcol_q <= '0; cib_q <= '0; bcol_q <= '0;
        if (13'(prow_q) + 13'd1 >= lc) begin
          prow_q <= '0; rib_q <= '0; brow_q <= '0;
        end else begin
          prow_q <= prow_q + 12'd1;
          if (6'(rib_q) + 6'd1 >= e) begin
            rib_q  <= '0;
            brow_q <= brow_q + 12'd1;
          end else begin
            rib_q <= rib_q + 5'd1;
          end
        end
      end else begin
        pcol_q <= pcol_q + 12'd1;
        if (in_cols) begin
          if (6'(cib_q) + 6'd1 >= e) begin
            cib_q  <= '0;
            bcol_q <= bcol_q + 9'd1;
          end else begin
            cib_q <= cib_q + 5'd1;
          end
        end
      end
    end
  end

  // column sum memory, read on accept, written back in the next cycle
  logic [SumW-1:0] sums_mem [MaxBlocksAcross];
  logic [SumW-1:0] rd_q, wr_data_q;
  logic [ColW-1:0] s1_col_q, wr_col_q;
  logic            s1_v_q, s1_first_q, s1_last_q, wr_v_q;
  logic [7:0]      s1_px_q;
  logic [8:0]      s1_bcol_q;
  logic [11:0]     s1_drow_q;
  logic            s1_lf_q;
  logic [SumW-1:0] old_sum, new_sum;
  logic [11:0]     drow;
  logic            lf;

  assign drow = brow_q - sync_rows_q[11:0];
  assign lf   = (10'(bcol_q) == ba - 10'd1) && (13'(drow) + 13'd1 == data_rows_q);

  always_ff @(posedge clk_i) begin
    if (accept) rd_q <= sums_mem[bcol_q];
    if (s1_v_q) sums_mem[s1_col_q] <= new_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      wr_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept && inner_hit;
      wr_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q   <= bcol_q;
      s1_first_q <= first_hit;
      s1_last_q  <= last_hit;
      s1_px_q    <= pix_in.data.pixel;
      s1_bcol_q  <= bcol_q;
      s1_drow_q  <= drow;
      s1_lf_q    <= lf;
    end
    wr_col_q  <= s1_col_q;
    wr_data_q <= new_sum;
  end

  // forward the sum written in the cycle of the read
  always_comb begin
    old_sum = rd_q;
    if (wr_v_q && wr_col_q == s1_col_q) old_sum = wr_data_q;
    new_sum = s1_first_q ? SumW'(s1_px_q) : old_sum + SumW'(s1_px_q);
  end

  // divider and result hold
  logic        div_start, div_done;
  logic [7:0]  quot;
  logic [10:0] div_val;
  logic [8:0]  r_bcol_q;
  logic [11:0] r_drow_q;
  logic        r_lf_q;
  sym_t        obuf_q;

  assign div_start = s1_v_q && s1_last_q;
  assign div_val   = 11'(inner) * 11'(inner);

  bmsd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (new_sum),
    .div_i   (div_val),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      r_bcol_q <= s1_bcol_q;
      r_drow_q <= s1_drow_q;
      r_lf_q   <= s1_lf_q;
    end
  end

  // busy from a last-pixel accept until its symbol is stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      obuf_full_q <= 1'b0;
    end else begin
      if (accept && inner_hit && last_hit) busy_q <= 1'b1;
      else if (div_done) busy_q <= 1'b0;
      if (div_done || (accept && empty_emit)) obuf_full_q <= 1'b1;
      else if (sym_out.ready) obuf_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      obuf_q.symbol        <= level_of(quot, bpb_q);
      obuf_q.block_mean    <= quot;
      obuf_q.block_column  <= r_bcol_q;
      obuf_q.data_row      <= r_drow_q;
      obuf_q.last_of_frame <= r_lf_q;
    end else if (accept && empty_emit) begin
      obuf_q.symbol        <= 3'd0;
      obuf_q.block_mean    <= 8'd0;
      obuf_q.block_column  <= bcol_q;
      obuf_q.data_row      <= drow;
      obuf_q.last_of_frame <= lf;
    end
  end

  assign sym_out.valid = obuf_full_q;
  assign sym_out.data  = obuf_q;
endmodule

@@ hdl/bmsd_checker.sv @@
// port-level checker for the block mean symbol decoder, bound to the top level
module bmsd_checker
  import bmsd_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input sym_t out_data
);
  // a waiting symbol blocks new pixels
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("pixel taken while symbol pending");

  // a stalled symbol holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("symbol dropped");

  // a zero mean with a nonzero symbol cannot happen
  a_sym_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.block_mean == 8'd0 |-> out_data.symbol == 3'd0)
    else $error("symbol inconsistent with mean");
endmodule

bind block_mean_symbol_decoder bmsd_checker u_bmsd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (sym_out.valid),
  .out_ready (sym_out.ready),
  .out_data  (sym_out.data)
);
